@@ sv/frt_pkg.sv @@
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types, constants and helpers of the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

  // slot count is a power of two: the slot index is the low frame bits
  localparam int SLOT_COUNT  = 8;
  localparam int MAX_PACKETS = 64;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int FRAME_W = 16;
  localparam int INDEX_W = 16;
  localparam int COUNT_W = 16;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 3;
  localparam int SLOTO_W = 3;
  localparam int TOTAL_W = 7;
  localparam int WIN_W   = 16;

  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
  localparam logic [WIN_W-1:0]   WIN_RESET   = 16'h8000;
  localparam logic [COUNT_W-1:0] MAX_PKT_VAL = COUNT_W'(MAX_PACKETS);

  typedef enum logic [STAT_W-1:0] {
    ST_OLD      = 3'd0,
    ST_STORED   = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_TOO_MANY = 3'd3,
    ST_SHORT    = 3'd4
  } status_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [INDEX_W-1:0] packet_index;
    logic [COUNT_W-1:0] packets_in_frame;
    logic               sync_flag;
    logic               whole_packet;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [FRAME_W-1:0]  done_frame;
    logic [SLOTO_W-1:0]  slot_used;
    logic [TOTAL_W-1:0]  fragment_total;
  } result_t;

  typedef struct packed {
    logic                   valid;
    logic [FRAME_W-1:0]     frame;
    logic [MAX_PACKETS-1:0] seen_map;
    logic [CNT_W-1:0]       stored_count;
  } slot_t;

  // write command from the decision logic into the slot table
  typedef struct packed {
    logic                   en;
    logic                   sync;
    logic [SLOT_W-1:0]      idx;
    slot_t                  slot;
    logic                   deliver;
    logic [FRAME_W-1:0]     frame;
  } upd_t;

  function automatic logic [MAX_PACKETS-1:0] low_mask(input logic [COUNT_W-1:0] c);
    logic [MAX_PACKETS-1:0] m;
    for (int i = 0; i < MAX_PACKETS; i++) begin
      m[i] = (c > COUNT_W'(i));
    end
    return m;
  endfunction

  function automatic logic [MAX_PACKETS-1:0] bit_of(input logic [INDEX_W-1:0] p);
    logic [MAX_PACKETS-1:0] m;
    for (int i = 0; i < MAX_PACKETS; i++) begin
      m[i] = (p == INDEX_W'(i));
    end
    return m;
  endfunction

endpackage

@@ sv/frame_fragment_reassembly_tracker_core.sv @@
// ----------------------------------------------------------------------------
// frame_fragment_reassembly_tracker_core
// Fragment header tracker: per-slot bitmap reassembly with a serial window.
// ----------------------------------------------------------------------------
//   channel  direction  beat contents
//   in_      slave      tdata: frame_number, packet_index, packets_in_frame
//                       tuser: sync_flag, whole_packet
//   out_     master     tdata: done_frame, slot_used, fragment_total
//                       tuser: status
//   cfg_     slave      data: newer_window
//
// One beat per cycle sustained while out_tready stays high; a beat passes the
// input register, then the result register, before its result is presented.
// The slot table is read and written in the cycle a beat moves from the input
// register to the result register, so the next beat sees the updated state.
// Stalls on out_tready hold the result register and back up into the input
// register; in_tready drops only when both are full.
// Reset (synchronous, rst_n low) empties all slots and the delivered frame.
// ----------------------------------------------------------------------------
module frame_fragment_reassembly_tracker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // frame_number, packet_index, packets_in_frame
  input  logic [1:0]  in_tuser,   // sync_flag, whole_packet
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // done_frame, slot_used, fragment_total, zero pad
  output logic [2:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // newer_window
);
  import frt_pkg::*;

  logic                 in_v_r;
  item_t                in_item_r;
  logic                 out_v_r;
  logic                 out_v_nxt;
  result_t              out_res_r;
  logic [WIN_W-1:0]     window_r;
  logic                 advance;
  logic [SLOT_W-1:0]    slot_idx;
  slot_t                rd_slot;
  logic                 dlv_valid;
  logic [FRAME_W-1:0]   dlv_frame;
  result_t              res;
  upd_t                 upd;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign cfg_ready = 1'b1;
  assign out_v_nxt = advance || (out_v_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      window_r <= WIN_RESET;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      out_v_r <= out_v_nxt;
      if (cfg_valid) begin
        window_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.frame_number     <= in_tdata[15:0];
      in_item_r.packet_index     <= in_tdata[31:16];
      in_item_r.packets_in_frame <= in_tdata[47:32];
      in_item_r.sync_flag        <= in_tuser[0];
      in_item_r.whole_packet     <= in_tuser[1];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  frt_slot_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (slot_idx),
    .rd_slot   (rd_slot),
    .dlv_valid (dlv_valid),
    .dlv_frame (dlv_frame),
    .upd       (upd)
  );

  frt_decide u_decide (
    .item      (in_item_r),
    .go        (advance),
    .rd_slot   (rd_slot),
    .dlv_valid (dlv_valid),
    .dlv_frame (dlv_frame),
    .window    (window_r),
    .slot_idx  (slot_idx),
    .res       (res),
    .upd       (upd)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_res_r.fragment_total, out_res_r.slot_used,
                       out_res_r.done_frame};
  assign out_tuser  = out_res_r.status;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("result register not loaded after a beat advanced");

  a_total_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.status != ST_COMPLETE) |-> out_res_r.fragment_total == '0)
    else $error("fragment total set on a result that did not complete");

  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.status == ST_COMPLETE) |-> out_res_r.fragment_total != '0)
    else $error("completed frame reported with zero fragments");

  a_no_update_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |-> !upd.en)
    else $error("slot table written without a beat advancing");

endmodule

@@ sv/frt_slot_table.sv @@
// ----------------------------------------------------------------------------
// frt_slot_table
// Slot registers and last-delivered frame, one read port and one update port.
// ----------------------------------------------------------------------------
module frt_slot_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [frt_pkg::SLOT_W-1:0]    rd_idx,
  output frt_pkg::slot_t                rd_slot,
  output logic                          dlv_valid,
  output logic [frt_pkg::FRAME_W-1:0]   dlv_frame,
  input  frt_pkg::upd_t                 upd
);
  import frt_pkg::*;

  logic [SLOT_COUNT-1:0]  valid_r;
  logic [SLOT_COUNT-1:0]  valid_nxt;
  logic [FRAME_W-1:0]     frame_r [SLOT_COUNT];
  logic [MAX_PACKETS-1:0] map_r   [SLOT_COUNT];
  logic [CNT_W-1:0]       count_r [SLOT_COUNT];
  logic                   dlv_valid_r;
  logic                   dlv_valid_nxt;
  logic [FRAME_W-1:0]     dlv_frame_r;

  always_comb begin
    rd_slot.valid        = valid_r[rd_idx];
    rd_slot.frame        = frame_r[rd_idx];
    rd_slot.seen_map     = map_r[rd_idx];
    rd_slot.stored_count = count_r[rd_idx];
  end

  assign dlv_valid = dlv_valid_r;
  assign dlv_frame = dlv_frame_r;

  always_comb begin
    valid_nxt     = valid_r;
    dlv_valid_nxt = dlv_valid_r;
    if (upd.en) begin
      if (upd.sync) begin
        valid_nxt     = '0;
        dlv_valid_nxt = 1'b0;
      end
      valid_nxt[upd.idx] = upd.slot.valid;
      if (upd.deliver) begin
        dlv_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      dlv_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      dlv_valid_r <= dlv_valid_nxt;
    end
  end

  // contents of a slot only matter while its valid bit is set
  always_ff @(posedge clk) begin
    if (upd.en) begin
      frame_r[upd.idx] <= upd.slot.frame;
      map_r[upd.idx]   <= upd.slot.seen_map;
      count_r[upd.idx] <= upd.slot.stored_count;
      if (upd.deliver) begin
        dlv_frame_r <= upd.frame;
      end
    end
  end

endmodule

@@ sv/frt_decide.sv @@
// ----------------------------------------------------------------------------
// frt_decide
// Window test, slot restart, bitmap and count update, completion check.
// ----------------------------------------------------------------------------
module frt_decide (
  input  frt_pkg::item_t                item,
  input  logic                          go,
  input  frt_pkg::slot_t                rd_slot,
  input  logic                          dlv_valid,
  input  logic [frt_pkg::FRAME_W-1:0]   dlv_frame,
  input  logic [frt_pkg::WIN_W-1:0]     window,
  output logic [frt_pkg::SLOT_W-1:0]    slot_idx,
  output frt_pkg::result_t              res,
  output frt_pkg::upd_t                 upd
);
  import frt_pkg::*;

  logic                   checked;
  logic                   slot_live;
  logic                   dlv_live;
  logic [FRAME_W-1:0]     dist_dlv;
  logic [FRAME_W-1:0]     dist_slot;
  logic                   newer;
  logic                   same;
  logic [MAX_PACKETS-1:0] map_new;
  logic [CNT_W-1:0]       cnt_base;
  logic [CNT_W-1:0]       cnt_new;
  logic [MAX_PACKETS-1:0] need;
  logic                   complete;

  assign slot_idx = item.frame_number[SLOT_W-1:0];

  always_comb begin
    checked   = item.whole_packet && (item.packets_in_frame <= MAX_PKT_VAL);
    // a sync empties everything before the window test
    slot_live = rd_slot.valid && !item.sync_flag;
    dlv_live  = dlv_valid && !item.sync_flag;
    dist_dlv  = item.frame_number - dlv_frame;
    dist_slot = item.frame_number - rd_slot.frame;
    newer     = (!dlv_live || (dist_dlv < window)) &&
                (!slot_live || (dist_slot < window));
    same      = slot_live && (rd_slot.frame == item.frame_number);
    map_new   = (same ? rd_slot.seen_map : '0) | bit_of(item.packet_index);
    cnt_base  = same ? rd_slot.stored_count : '0;
    cnt_new   = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 1'b1;
    need      = low_mask(item.packets_in_frame);
    complete  = (COUNT_W'(cnt_new) == item.packets_in_frame) && ((map_new & need) == need);

    res.done_frame     = item.frame_number;
    res.slot_used      = SLOTO_W'(slot_idx);
    res.fragment_total = '0;
    if (!item.whole_packet) begin
      res.status = ST_SHORT;
    end else if (!checked) begin
      res.status = ST_TOO_MANY;
    end else if (!newer) begin
      res.status = ST_OLD;
    end else if (complete) begin
      res.status         = ST_COMPLETE;
      res.fragment_total = TOTAL_W'(item.packets_in_frame);
    end else begin
      res.status = ST_STORED;
    end

    upd.en                = go && checked && newer;
    upd.sync              = item.sync_flag;
    upd.idx               = slot_idx;
    upd.slot.valid        = !complete;
    upd.slot.frame        = item.frame_number;
    upd.slot.seen_map     = map_new;
    upd.slot.stored_count = cnt_new;
    upd.deliver           = complete;
    upd.frame             = item.frame_number;
  end

endmodule

@@ test/frame_fragment_reassembly_tracker_core_tb.sv @@
// ----------------------------------------------------------------------------
// frame_fragment_reassembly_tracker_core_tb
// Streams fragment headers into the tracker and checks every result beat
// against a cycle-free slot-table predictor, across several window settings.
// ----------------------------------------------------------------------------
module frame_fragment_reassembly_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // slot table predictor plus the queue of results still owed by the block
  class reassembly_ledger;
    logic [FRAME_W-1:0]     slot_frame [SLOT_COUNT];
    bit                     slot_valid [SLOT_COUNT];
    logic [MAX_PACKETS-1:0] slot_seen  [SLOT_COUNT];
    logic [CNT_W-1:0]       slot_count [SLOT_COUNT];
    logic [FRAME_W-1:0]     last_frame;
    bit                     last_valid;
    logic [WIN_W-1:0]       window;
    result_t                awaited_results[$];
    int                     fails;

    function new();
      wipe();
      window = WIN_RESET;
      fails  = 0;
    endfunction

    function void wipe();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_frame[i] = '0;
        slot_valid[i] = 1'b0;
        slot_seen[i]  = '0;
        slot_count[i] = '0;
      end
      last_frame = '0;
      last_valid = 1'b0;
    endfunction

    function bit ahead(logic [FRAME_W-1:0] f, logic [FRAME_W-1:0] ref_frame);
      logic [FRAME_W-1:0] span;
      span = f - ref_frame;
      return span < window;
    endfunction

    function void note_fragment(item_t it);
      result_t                r;
      int                     s;
      logic [FRAME_W-1:0]     f;
      logic [MAX_PACKETS-1:0] need;
      bit                     fresh;
      f = it.frame_number;
      s = int'(f[SLOT_W-1:0]);
      r.status         = ST_STORED;
      r.done_frame     = f;
      r.slot_used      = SLOTO_W'(s);
      r.fragment_total = '0;
      if (!it.whole_packet) begin
        r.status = ST_SHORT;
      end else if (it.packets_in_frame > MAX_PKT_VAL) begin
        r.status = ST_TOO_MANY;
      end else begin
        if (it.sync_flag) wipe();
        fresh = (!last_valid || ahead(f, last_frame)) &&
                (!slot_valid[s] || ahead(f, slot_frame[s]));
        if (!fresh) begin
          r.status = ST_OLD;
        end else begin
          if (!(slot_valid[s] && slot_frame[s] == f)) begin
            slot_valid[s] = 1'b1;
            slot_frame[s] = f;
            slot_seen[s]  = '0;
            slot_count[s] = '0;
          end
          if (it.packet_index < MAX_PACKETS) slot_seen[s][it.packet_index[5:0]] = 1'b1;
          if (slot_count[s] != CNT_MAX) slot_count[s] = slot_count[s] + 1'b1;
          if (it.packets_in_frame >= MAX_PACKETS) need = '1;
          else need = (64'(1) << it.packets_in_frame) - 64'(1);
          if (COUNT_W'(slot_count[s]) == it.packets_in_frame &&
              (slot_seen[s] & need) == need) begin
            slot_valid[s]    = 1'b0;
            slot_frame[s]    = '0;
            slot_seen[s]     = '0;
            slot_count[s]    = '0;
            last_frame       = f;
            last_valid       = 1'b1;
            r.status         = ST_COMPLETE;
            r.fragment_total = it.packets_in_frame[TOTAL_W-1:0];
          end
        end
      end
      awaited_results = {awaited_results, r};
    endfunction

    function void check_verdict(logic [31:0] tdata, logic [STAT_W-1:0] tuser);
      result_t exp;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %0d", tdata, tuser);
        fails++;
        return;
      end
      exp = awaited_results.pop_front();
      if (tuser !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, tuser);
        fails++;
      end
      if (tdata[15:0] !== exp.done_frame) begin
        $error("done_frame: expected %0d, got %0d", exp.done_frame, tdata[15:0]);
        fails++;
      end
      if (tdata[18:16] !== exp.slot_used) begin
        $error("slot_used: expected %0d, got %0d", exp.slot_used, tdata[18:16]);
        fails++;
      end
      if (tdata[25:19] !== exp.fragment_total) begin
        $error("fragment_total: expected %0d, got %0d", exp.fragment_total, tdata[25:19]);
        fails++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  reassembly_ledger books = new();
  bit               no_gaps = 1'b0;
  int               cycles  = 0;
  int               sent    = 0;
  logic [15:0]      frame_cur = 16'd10;
  item_t            beat_plan[$];

  frame_fragment_reassembly_tracker_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(0, 99) < 7);
  endfunction

  always @(posedge clk) begin
    out_tready <= !take_gap();
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) books.check_verdict(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic item_t frag(logic [15:0] f, logic [15:0] p, logic [15:0] c,
                                 bit sync, bit whole);
    item_t it;
    it.frame_number     = f;
    it.packet_index     = p;
    it.packets_in_frame = c;
    it.sync_flag        = sync;
    it.whole_packet     = whole;
    return it;
  endfunction

  task automatic send_beat(item_t it);
    while (take_gap()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.packets_in_frame, it.packet_index, it.frame_number};
    in_tuser  <= {it.whole_packet, it.sync_flag};
    do @(posedge clk); while (!in_tready);
    books.note_fragment(it);
    sent++;
  endtask

  // stop driving and wait until every owed result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (books.awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(logic [15:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    books.window = v;
  endtask

  // well-formed frames, optionally with a flaw, fragments of all frames shuffled
  task automatic plan_frames(int nframes);
    item_t       t;
    int          c;
    int          j;
    logic [15:0] f;
    for (int k = 0; k < nframes; k++) begin
      frame_cur = frame_cur + 16'($urandom_range(1, 4));
      if ($urandom_range(0, 19) == 0) frame_cur = frame_cur + 16'($urandom_range(5, 2000));
      f = frame_cur;
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_PACKETS) : $urandom_range(1, 8);
      for (int p = 0; p < c; p++) beat_plan = {beat_plan, frag(f, 16'(p), 16'(c), 1'b0, 1'b1)};
      case ($urandom_range(0, 9))
        0: beat_plan = {beat_plan, frag(f, 16'($urandom_range(0, c - 1)), 16'(c), 1'b0, 1'b1)};
        1: beat_plan = {beat_plan, frag(f, 16'($urandom_range(0, c - 1)), 16'(c), 1'b0, 1'b0)};
        2: void'(beat_plan.pop_back());
        default: ;
      endcase
    end
    for (int i = beat_plan.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = beat_plan[i];
      beat_plan[i] = beat_plan[j];
      beat_plan[j] = t;
    end
    while (beat_plan.size() != 0) send_beat(beat_plan.pop_front());
  endtask

  task automatic run_random(int quota);
    int          stop_at;
    int          pick;
    logic [15:0] f;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        plan_frames($urandom_range(1, 3));
      end else if (pick < 68) begin
        f = 16'($urandom);
        send_beat(frag(f, 16'($urandom_range(0, 3)), 16'($urandom_range(1, 4)),
                       1'b1, $urandom_range(0, 3) != 0));
        frame_cur = f;
      end else if (pick < 78) begin
        send_beat(frag(frame_cur - 16'($urandom_range(1, 40000)), 16'($urandom_range(0, 7)),
                       16'($urandom_range(1, 8)), 1'b0, 1'b1));
      end else if (pick < 90) begin
        send_beat(frag(16'($urandom), 16'($urandom),
                       $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64)),
                       $urandom_range(0, 19) == 0, 1'($urandom_range(0, 1))));
      end else if (pick < 95) begin
        send_beat(frag(16'($urandom), 16'($urandom),
                       16'($urandom_range(MAX_PACKETS + 1, 65535)),
                       1'($urandom_range(0, 1)), 1'b1));
      end else begin
        send_beat(frag(16'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom_range(0, 1)), 1'b0));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short and oversized beats ignore the sync flag
    send_beat(frag(16'd5, 16'd0, 16'd1, 1'b1, 1'b0));
    send_beat(frag(16'd6, 16'd0, 16'd65, 1'b1, 1'b1));
    send_beat(frag(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
    // single-fragment frame, then a three-fragment frame out of order
    send_beat(frag(16'd0, 16'd0, 16'd1, 1'b0, 1'b1));
    send_beat(frag(16'd1, 16'd2, 16'd3, 1'b0, 1'b1));
    send_beat(frag(16'd1, 16'd0, 16'd3, 1'b0, 1'b1));
    send_beat(frag(16'd1, 16'd1, 16'd3, 1'b0, 1'b1));
    // zero packet count never completes
    send_beat(frag(16'd2, 16'd0, 16'd0, 1'b0, 1'b1));
    // indexes past the bitmap still count as stored
    send_beat(frag(16'd3, 16'd64, 16'd2, 1'b0, 1'b1));
    send_beat(frag(16'd3, 16'hFFFF, 16'd2, 1'b0, 1'b1));
    send_beat(frag(16'd3, 16'd0, 16'd2, 1'b0, 1'b1));
    send_beat(frag(16'd3, 16'd1, 16'd2, 1'b0, 1'b1));
    // a duplicate blocks completion
    send_beat(frag(16'd4, 16'd0, 16'd2, 1'b0, 1'b1));
    send_beat(frag(16'd4, 16'd0, 16'd2, 1'b0, 1'b1));
    send_beat(frag(16'd4, 16'd1, 16'd2, 1'b0, 1'b1));
    // behind the delivered frame
    send_beat(frag(16'h9000, 16'd0, 16'd1, 1'b0, 1'b1));
    send_beat(frag(16'hFFFF, 16'd0, 16'd1, 1'b0, 1'b1));
    // sync clears everything, then frames at and past the window edge are old
    send_beat(frag(16'hFFFF, 16'd0, 16'd1, 1'b1, 1'b1));
    send_beat(frag(16'h7FFF, 16'd63, 16'd64, 1'b0, 1'b1));
    send_beat(frag(16'h8000, 16'd1, 16'd1, 1'b0, 1'b1));
    frame_cur = 16'h8010;

    run_random(250);

    // stored count saturates: the repeats keep this frame from completing
    frame_cur = frame_cur + 16'd1;
    repeat (130) send_beat(frag(frame_cur, 16'd5, 16'd2, 1'b0, 1'b1));
    send_beat(frag(frame_cur, 16'd0, 16'd2, 1'b0, 1'b1));
    send_beat(frag(frame_cur, 16'd1, 16'd2, 1'b0, 1'b1));

    write_window(16'd1);
    send_beat(frag(frame_cur + 16'd1, 16'd0, 16'd1, 1'b1, 1'b1));
    send_beat(frag(frame_cur + 16'd1, 16'd0, 16'd1, 1'b0, 1'b1));
    run_random(60);

    write_window(16'hFFFF);
    no_gaps = 1'b1;
    run_random(250);
    no_gaps = 1'b0;

    write_window(16'd0);
    run_random(30);

    write_window(16'd300);
    send_beat(frag(frame_cur, 16'd0, 16'd1, 1'b1, 1'b1));
    run_random(150);

    write_window(16'($urandom_range(1, 65535)));
    run_random(100);

    write_window(WIN_RESET);
    send_beat(frag(frame_cur, 16'd0, 16'd1, 1'b1, 1'b1));
    run_random(100);

    settle();
    if (books.fails == 0 && books.awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
